// ===== rtl/trt_pkg.sv =====
package trt_pkg;

	typedef enum logic [2:0] {
		PORT_LB   = 3'd0,
		PORT_XP   = 3'd1,
		PORT_XN   = 3'd2,
		PORT_YP   = 3'd3,
		PORT_YN   = 3'd4,
		PORT_ZP   = 3'd5,
		PORT_ZN   = 3'd6,
		PORT_NONE = 3'd7
	} port_t;

	localparam int NUM_DIMS  = 3;
	localparam int NUM_PORTS = 7;
	localparam int REG_IDX_W = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_NODE     = 3'd0;
	localparam reg_idx_t REG_ORIGIN   = 3'd1;
	localparam reg_idx_t REG_MAX      = 3'd2;
	localparam reg_idx_t REG_LOOPBACK = 3'd3;
	localparam reg_idx_t REG_PRESENT  = 3'd4;

	localparam port_t POS_PORT [NUM_DIMS] = '{PORT_XP, PORT_YP, PORT_ZP};
	localparam port_t NEG_PORT [NUM_DIMS] = '{PORT_XN, PORT_YN, PORT_ZN};

	typedef logic [NUM_PORTS-1:0] pmask_t;

endpackage

// ===== rtl/torus_dimension_order_route_core.sv =====
// Dimension-order route computation for a 3D torus node. One packet header is
// taken per clock (busy is never raised) and its result appears on the result
// ports, with done high, once it has passed the three pipeline stages (distance
// sums, per-dimension link choice, first-differing-dimension select), each of
// which ends in a register. Results are one-cycle strobes and cannot be
// stalled. Configuration writes take effect at once and must be made while no
// header is in flight.
module torus_dimension_order_route_core
	import trt_pkg::*;
#(
	parameter int COORD_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [COORD_BITS-1:0]   dest_x,
	input  logic [COORD_BITS-1:0]   dest_y,
	input  logic [COORD_BITS-1:0]   dest_z,
	input  logic                    is_broadcast,
	input  logic                    cfg_we,
	input  reg_idx_t                cfg_index,
	input  logic [((3*COORD_BITS > NUM_PORTS) ? 3*COORD_BITS : NUM_PORTS)-1:0] cfg_data,
	output logic                    done,
	output logic [2:0]              out_port,
	output logic [NUM_PORTS-1:0]    port_mask,
	output logic                    no_route
);

	localparam int CW = 3 * COORD_BITS;
	localparam int DW = COORD_BITS + 3;

	logic [CW-1:0] node_q, origin_q, max_q, loop_q;
	pmask_t        present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q    <= '0;
			origin_q  <= '0;
			max_q     <= '0;
			loop_q    <= '0;
			present_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE:     node_q    <= cfg_data[CW-1:0];
				REG_ORIGIN:   origin_q  <= cfg_data[CW-1:0];
				REG_MAX:      max_q     <= cfg_data[CW-1:0];
				REG_LOOPBACK: loop_q    <= cfg_data[CW-1:0];
				REG_PRESENT:  present_q <= cfg_data[NUM_PORTS-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// stage 1: direct and wrap-around distances for every dimension
	logic [CW-1:0]              dest_packed;
	logic [COORD_BITS-1:0]      dest_c [NUM_DIMS];
	logic signed [DW-1:0]       pos_d, neg_d;
	logic signed [DW-1:0]       pos_dist [NUM_DIMS];
	logic signed [DW-1:0]       neg_dist [NUM_DIMS];
	logic [NUM_DIMS-1:0]        pref_neg, differ;

	function automatic logic signed [DW-1:0] ext(input logic [COORD_BITS-1:0] v);
		return signed'({3'b000, v});
	endfunction

	assign dest_packed = {dest_z, dest_y, dest_x};
	assign dest_c[0] = dest_x;
	assign dest_c[1] = dest_y;
	assign dest_c[2] = dest_z;

	always_comb begin
		for (int d = 0; d < NUM_DIMS; d++) begin
			logic signed [DW-1:0] here, lo, hi, dst, offset;
			here   = ext(node_q[d*COORD_BITS +: COORD_BITS]);
			lo     = ext(origin_q[d*COORD_BITS +: COORD_BITS]);
			hi     = ext(max_q[d*COORD_BITS +: COORD_BITS]);
			dst    = ext(dest_c[d]);
			offset = dst - here;
			differ[d]   = (dest_c[d] != node_q[d*COORD_BITS +: COORD_BITS]);
			pref_neg[d] = offset[DW-1];
			if (offset[DW-1]) begin
				neg_dist[d] = -offset;
				pos_dist[d] = (hi - here) + (dst - lo) + DW'(1);
			end else begin
				pos_dist[d] = offset;
				neg_dist[d] = (here - lo) + (hi - dst) + DW'(1);
			end
		end
	end

	assign pos_d = pos_dist[0];
	assign neg_d = neg_dist[0];

	logic                 valid_s1, bcast_s1, local_s1;
	logic [NUM_DIMS-1:0]  differ_s1, pref_neg_s1;
	logic signed [DW-1:0] pos_dist_s1 [NUM_DIMS];
	logic signed [DW-1:0] neg_dist_s1 [NUM_DIMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bcast_s1    <= is_broadcast;
			local_s1    <= (dest_packed == loop_q) || (dest_packed == node_q);
			differ_s1   <= differ;
			pref_neg_s1 <= pref_neg;
			for (int d = 0; d < NUM_DIMS; d++) begin
				pos_dist_s1[d] <= (d == 0) ? pos_d : pos_dist[d];
				neg_dist_s1[d] <= (d == 0) ? neg_d : neg_dist[d];
			end
		end
	end

	// stage 2: link choice per dimension
	port_t dim_port [NUM_DIMS];

	always_comb begin
		for (int d = 0; d < NUM_DIMS; d++) begin
			logic pos_ok, neg_ok;
			pos_ok = present_q[POS_PORT[d]];
			neg_ok = present_q[NEG_PORT[d]];
			if (pos_dist_s1[d] < neg_dist_s1[d] && pos_ok)
				dim_port[d] = POS_PORT[d];
			else if (pos_dist_s1[d] > neg_dist_s1[d] && neg_ok)
				dim_port[d] = NEG_PORT[d];
			else if (pref_neg_s1[d])
				dim_port[d] = neg_ok ? NEG_PORT[d] : (pos_ok ? POS_PORT[d] : PORT_NONE);
			else
				dim_port[d] = pos_ok ? POS_PORT[d] : (neg_ok ? NEG_PORT[d] : PORT_NONE);
		end
	end

	logic                valid_s2, bcast_s2, local_s2;
	logic [NUM_DIMS-1:0] differ_s2;
	port_t               dim_port_s2 [NUM_DIMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			bcast_s2    <= bcast_s1;
			local_s2    <= local_s1;
			differ_s2   <= differ_s1;
			dim_port_s2 <= dim_port;
		end
	end

	// stage 3: loopback if local, else first differing dimension in X, Y, Z order; broadcast takes the present mask
	port_t  sel_port;
	port_t  fin_port;
	pmask_t fin_mask;
	logic   fin_none;

	always_comb begin
		if (local_s2)
			sel_port = PORT_LB;
		else if (differ_s2[0])
			sel_port = dim_port_s2[0];
		else if (differ_s2[1])
			sel_port = dim_port_s2[1];
		else if (differ_s2[2])
			sel_port = dim_port_s2[2];
		else
			sel_port = PORT_NONE;

		if (bcast_s2) begin
			fin_port = PORT_NONE;
			fin_mask = present_q;
			fin_none = 1'b0;
		end else if (sel_port == PORT_NONE) begin
			fin_port = PORT_NONE;
			fin_mask = '0;
			fin_none = 1'b1;
		end else begin
			fin_port = sel_port;
			fin_mask = pmask_t'(1) << sel_port;
			fin_none = 1'b0;
		end
	end

	logic   valid_s3, no_route_s3;
	port_t  port_s3;
	pmask_t mask_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else         valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			port_s3     <= fin_port;
			mask_s3     <= fin_mask;
			no_route_s3 <= fin_none;
		end
	end

	assign done      = valid_s3;
	assign out_port  = port_s3;
	assign port_mask = mask_s3;
	assign no_route  = no_route_s3;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##2 done)
		else $error("transaction did not complete three cycles after start");

	a_no_route: assert property (@(posedge clk) disable iff (!arst_n)
		(done && no_route) |-> (out_port == PORT_NONE && port_mask == '0))
		else $error("dropped packet carries a port");

	a_unicast_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_port != PORT_NONE) |-> ($onehot(port_mask) && port_mask[out_port]))
		else $error("unicast port mask does not match port");

	a_bcast_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_port == PORT_NONE && !no_route) |-> (port_mask == present_q))
		else $error("broadcast mask differs from present ports");

endmodule

// ===== tb/torus_dimension_order_route_core_tb.sv =====
module torus_dimension_order_route_core_tb;
	import trt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 8;
	localparam int CW = 3 * CB;
	localparam int PHASES = 14;
	localparam int PHASE_ITEMS = 125;
	localparam int IDLE_PCT = 37;
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		port_t  port;
		pmask_t mask;
		logic   drop;
	} route_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [CB-1:0] dest_x;
	logic [CB-1:0] dest_y;
	logic [CB-1:0] dest_z;
	logic          is_broadcast;
	logic          cfg_we;
	reg_idx_t      cfg_index;
	logic [CW-1:0] cfg_data;
	logic          done;
	logic [2:0]    out_port;
	pmask_t        port_mask;
	logic          no_route;

	// shadow copy of the configuration registers
	logic [CW-1:0] node_c;
	logic [CW-1:0] origin_c;
	logic [CW-1:0] max_c;
	logic [CW-1:0] loop_c;
	pmask_t        present_c;

	route_t route_q[$];
	int     err_count;
	bit     idle_on;

	torus_dimension_order_route_core #(.COORD_BITS(CB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.dest_z(dest_z),
		.is_broadcast(is_broadcast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.out_port(out_port),
		.port_mask(port_mask),
		.no_route(no_route)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	function automatic int coord(logic [CW-1:0] word, int dim);
		return int'(word[dim*CB +: CB]);
	endfunction

	function automatic port_t pick_link(int dim, int dst);
		int   here, lo, hi, off, pd, nd;
		logic pos_ok, neg_ok, neg_first;
		here = coord(node_c, dim);
		lo = coord(origin_c, dim);
		hi = coord(max_c, dim);
		pos_ok = present_c[POS_PORT[dim]];
		neg_ok = present_c[NEG_PORT[dim]];
		off = dst - here;
		if (off < 0) begin
			nd = -off;
			pd = (hi - here) + (dst - lo) + 1;
			neg_first = 1'b1;
		end else begin
			pd = off;
			nd = (here - lo) + (hi - dst) + 1;
			neg_first = 1'b0;
		end
		if (pd < nd && pos_ok)
			return POS_PORT[dim];
		if (pd > nd && neg_ok)
			return NEG_PORT[dim];
		// tie, or the shorter link is missing
		if (neg_first) begin
			if (neg_ok) return NEG_PORT[dim];
			if (pos_ok) return POS_PORT[dim];
		end else begin
			if (pos_ok) return POS_PORT[dim];
			if (neg_ok) return NEG_PORT[dim];
		end
		return PORT_NONE;
	endfunction

	function automatic route_t predict_route(logic [CB-1:0] dx, logic [CB-1:0] dy,
			logic [CB-1:0] dz, logic bc);
		route_t        r;
		logic [CW-1:0] dest_word;
		port_t         p;
		dest_word = {dz, dy, dx};
		if (bc) begin
			r.port = PORT_NONE;
			r.mask = present_c;
			r.drop = 1'b0;
			return r;
		end
		if (dest_word == loop_c || dest_word == node_c)
			p = PORT_LB;
		else if (int'(dx) != coord(node_c, 0))
			p = pick_link(0, int'(dx));
		else if (int'(dy) != coord(node_c, 1))
			p = pick_link(1, int'(dy));
		else
			p = pick_link(2, int'(dz));
		r.port = p;
		r.mask = (p == PORT_NONE) ? pmask_t'(0) : pmask_t'(1) << p;
		r.drop = (p == PORT_NONE);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	always @(posedge clk) begin
		route_t exp_r;
		if (arst_n && done) begin
			if (route_q.size() == 0) begin
				report_mismatch("result strobe with no packet outstanding");
			end else begin
				exp_r = route_q.pop_front();
				if (out_port !== exp_r.port)
					report_mismatch($sformatf("out_port %0d, expected %0d",
						out_port, exp_r.port));
				if (port_mask !== exp_r.mask)
					report_mismatch($sformatf("port_mask %07b, expected %07b",
						port_mask, exp_r.mask));
				if (no_route !== exp_r.drop)
					report_mismatch($sformatf("no_route %0b, expected %0b",
						no_route, exp_r.drop));
			end
		end
	end

	// one header transaction; start stays high into the next call
	task automatic send_header(logic [CB-1:0] dx, logic [CB-1:0] dy,
			logic [CB-1:0] dz, logic bc);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		dest_x <= dx;
		dest_y <= dy;
		dest_z <= dz;
		is_broadcast <= bc;
		do @(posedge clk); while (busy);
		route_q.insert(route_q.size(), predict_route(dx, dy, dz, bc));
	endtask

	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (route_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_NODE:     node_c = val;
			REG_ORIGIN:   origin_c = val;
			REG_MAX:      max_c = val;
			REG_LOOPBACK: loop_c = val;
			REG_PRESENT:  present_c = val[NUM_PORTS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [CW-1:0] node, logic [CW-1:0] lo,
			logic [CW-1:0] hi, logic [CW-1:0] lb, logic [CW-1:0] present);
		write_reg(REG_NODE, node);
		write_reg(REG_ORIGIN, lo);
		write_reg(REG_MAX, hi);
		write_reg(REG_LOOPBACK, lb);
		write_reg(REG_PRESENT, present);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// nothing written yet: all registers at reset value
	task automatic test_reset_state;
		send_header(8'h00, 8'h00, 8'h00, 1'b1);
		send_header(8'h00, 8'h00, 8'h00, 1'b0);
		send_header(8'h01, 8'h00, 8'h00, 1'b0);
		drain();
	endtask

	task automatic test_broadcast;
		set_config(24'h030201, 24'h000000, 24'h0f0f0f, 24'hffffff, 24'hffff7f);
		send_header(8'hff, 8'hff, 8'hff, 1'b1);
		drain();
		set_config(24'h030201, 24'h000000, 24'h0f0f0f, 24'hffffff, 24'h00002a);
		send_header(8'h03, 8'h02, 8'h01, 1'b1);
		drain();
	endtask

	// loopback port not marked present, still chosen
	task automatic test_local;
		set_config(24'h070605, 24'h000000, 24'h090909, 24'hffffff, 24'h00007e);
		send_header(8'h05, 8'h06, 8'h07, 1'b0);
		send_header(8'hff, 8'hff, 8'hff, 1'b0);
		send_header(8'h00, 8'h00, 8'h00, 1'b0);
		drain();
	endtask

	task automatic test_dim_order;
		set_config(24'h040405, 24'h000000, 24'h090909, 24'h808080, 24'h00007f);
		send_header(8'h07, 8'h04, 8'h04, 1'b0);
		send_header(8'h01, 8'h04, 8'h04, 1'b0);
		send_header(8'h00, 8'h04, 8'h04, 1'b0); // negative-offset tie
		send_header(8'h09, 8'h00, 8'h00, 1'b0);
		send_header(8'h05, 8'h09, 8'h00, 1'b0);
		send_header(8'h05, 8'h04, 8'h00, 1'b0);
		send_header(8'h05, 8'h04, 8'hff, 1'b0);
		drain();
	endtask

	task automatic test_missing_links;
		// only x- and y+ present
		set_config(24'h040404, 24'h000000, 24'h090909, 24'h808080, 24'h00000c);
		send_header(8'h05, 8'h04, 8'h04, 1'b0); // short x+ missing
		send_header(8'h04, 8'h02, 8'h04, 1'b0); // falls back to y+
		send_header(8'h04, 8'h04, 8'h05, 1'b0); // no z link
		drain();
		set_config(24'h040404, 24'h000000, 24'h090909, 24'h808080, 24'h000078);
		send_header(8'h03, 8'h04, 8'h04, 1'b0); // x links gone, y/z ignored
		drain();
	endtask

	// origin above max, node outside the range
	task automatic test_out_of_range;
		set_config(24'hc8c8c8, 24'h0a0a0a, 24'h050505, 24'h000000, 24'h00007f);
		write_reg(reg_idx_t'(REG_PRESENT + 1), 24'hffffff);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_header(8'h00, 8'hc8, 8'hc8, 1'b0);
		send_header(8'hc8, 8'hff, 8'hc8, 1'b0);
		send_header(8'hc8, 8'hc8, 8'h64, 1'b0);
		drain();
	endtask

	task automatic randomize_config;
		logic [CW-1:0] node, lo, hi, lb;
		logic [CW-1:0] present;
		int            l, h, mode;
		for (int d = 0; d < NUM_DIMS; d++) begin
			mode = $urandom_range(9);
			if (mode == 0) begin
				l = 0;
				h = 255;
			end else if (mode == 1) begin
				l = $urandom_range(255);
				h = $urandom_range(255);
			end else begin
				l = $urandom_range(250);
				h = l + $urandom_range(7);
			end
			lo[d*CB +: CB] = CB'(l);
			hi[d*CB +: CB] = CB'(h);
			node[d*CB +: CB] = (l <= h) ? CB'($urandom_range(h, l)) : CB'($urandom);
		end
		lb = ($urandom_range(1) == 0) ? CW'($urandom) : node ^ CW'(1 << $urandom_range(CW-1));
		present = CW'($urandom);
		mode = $urandom_range(7);
		if (mode == 0)
			present[NUM_PORTS-1:0] = '1;
		else if (mode == 1)
			present[NUM_PORTS-1:0] = '0;
		set_config(node, lo, hi, lb, present);
		if ($urandom_range(3) == 0) begin
			write_reg(reg_idx_t'($urandom_range(2**REG_IDX_W - 1, REG_PRESENT + 1)),
				CW'($urandom));
			@(negedge clk);
			cfg_we <= 1'b0;
		end
	endtask

	function automatic logic [CB-1:0] random_dest_coord(int dim);
		int l, h, sel;
		l = coord(origin_c, dim);
		h = coord(max_c, dim);
		sel = $urandom_range(9);
		if (sel < 4)
			return CB'(coord(node_c, dim));
		if (sel < 9 && l <= h)
			return CB'($urandom_range(h, l));
		return CB'($urandom);
	endfunction

	task automatic test_random;
		logic [CW-1:0] dw;
		int            sel;
		for (int ph = 0; ph < PHASES; ph++) begin
			randomize_config();
			// a long stretch with no idle cycles
			idle_on = (ph != 6 && ph != 7);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(99);
				if (sel < 5)
					dw = loop_c;
				else if (sel < 10)
					dw = node_c;
				else if (sel < 14)
					dw = CW'($urandom);
				else
					dw = {random_dest_coord(2), random_dest_coord(1), random_dest_coord(0)};
				send_header(dw[CB-1:0], dw[CB +: CB], dw[2*CB +: CB],
					$urandom_range(99) < 8);
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		dest_x = '0;
		dest_y = '0;
		dest_z = '0;
		is_broadcast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NODE;
		cfg_data = '0;
		node_c = '0;
		origin_c = '0;
		max_c = '0;
		loop_c = '0;
		present_c = '0;
		err_count = 0;
		idle_on = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_broadcast();
		test_local();
		test_dim_order();
		test_missing_links();
		test_out_of_range();
		test_random();

		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/trt_pkg.sv
rtl/torus_dimension_order_route_core.sv
tb/torus_dimension_order_route_core_tb.sv
